### rtl/core/rrbc_pkg.sv
// Shared types, constants and the arctangent table function for the
// rotated rectangle bounds check. No dependencies.
`default_nettype none

package rrbc_pkg;

  // Default configuration of the trig path
  localparam int DEF_TRIG_FRAC_BITS = 24;
  localparam int DEF_CORDIC_STAGES  = 24;

  // CORDIC working formats: x/y in Q40, z in Q60
  localparam int WORK_BITS = 40;
  localparam int XY_W      = 44;
  localparam int Z_W       = 64;
  localparam int RES_W     = 14;

  // Corner coordinate width after rounding (center plus rotated offset)
  localparam int NUM_W = 36;

  // Pipeline depth outside the CORDIC chain
  localparam int FRONT_LAT = 2;
  localparam int BACK_LAT  = 8;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  // Radians per residual step in Q60, split for two narrow multipliers
  localparam logic [63:0] PI_STEP    = PI_Q60 >> 15;
  localparam int          STEP_SPLIT = 24;
  localparam logic [22:0] STEP_HI    = PI_STEP[46:24];
  localparam logic [23:0] STEP_LO    = PI_STEP[23:0];

  localparam logic signed [XY_W-1:0] ONE_Q = XY_W'(1) << WORK_BITS;
  localparam logic signed [XY_W-1:0] GAIN_Q = XY_W'({GAIN_Q32, 8'b0});

  // Corner codes in check order
  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TR = 2'd2;
  localparam logic [1:0] CORNER_TL = 2'd3;

  // Rectangle carried alongside the trig computation
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        w;
    logic [30:0]        h;
    logic [1:0]         quad;
    logic               byp;
  } item_t;

  // One CORDIC cell's contents
  typedef struct packed {
    item_t                   item;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_t;

  // Board outline, inclusive bounds
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [32:0] max_x;
    logic signed [32:0] max_y;
  } bounds_t;

  // atan(2^-idx) in Q60: pi/4 for idx 0, alternating power series otherwise
  function automatic logic signed [Z_W-1:0] atan_q60(input int idx);
    longint          acc;
    longint unsigned term;
    int              k;
    acc = 0;
    if (idx == 0) begin
      acc = longint'(PI_Q60 >> 2);
    end else begin
      for (k = 0; idx * (2 * k + 1) <= 60; k++) begin
        term = (64'd1 << (60 - idx * (2 * k + 1))) / 64'(2 * k + 1);
        if (k[0]) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rrbc_front.sv
// Input stage: captures a rectangle and turns the angle residual into a
// Q60 radian value for the CORDIC chain. Depends on rrbc_pkg.
`default_nettype none

module rrbc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_i,
  input  logic signed [31:0]    center_x_i,
  input  logic signed [31:0]    center_y_i,
  input  logic [30:0]           rect_width_i,
  input  logic [30:0]           rect_height_i,
  input  logic [15:0]           angle_i,
  output logic                  vld_o,
  output rrbc_pkg::cordic_t     dat_o
);
  import rrbc_pkg::*;

  logic        vld_a_r;
  item_t       item_a_r;
  logic [36:0] phi_a_r;
  logic [37:0] plo_a_r;
  logic [RES_W-1:0] res;

  logic    vld_b_r;
  cordic_t dat_b_r;

  assign res = angle_i[RES_W-1:0];

  // Stage A: partial products of residual times pi step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= acc_i;
    end
  end

  always_ff @(posedge clk) begin
    item_a_r.cx   <= center_x_i;
    item_a_r.cy   <= center_y_i;
    item_a_r.w    <= rect_width_i;
    item_a_r.h    <= rect_height_i;
    item_a_r.quad <= angle_i[15:14];
    item_a_r.byp  <= (res == '0);
    phi_a_r       <= 37'(res) * 37'(STEP_HI);
    plo_a_r       <= 38'(res) * 38'(STEP_LO);
  end

  // Stage B: combine partial products, seed x with the CORDIC gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    dat_b_r.item <= item_a_r;
    dat_b_r.x    <= GAIN_Q;
    dat_b_r.y    <= '0;
    dat_b_r.z    <= $signed((Z_W'(phi_a_r) << STEP_SPLIT) + Z_W'(plo_a_r));
  end

  assign vld_o = vld_b_r;
  assign dat_o = dat_b_r;

endmodule

`default_nettype wire

### rtl/core/rrbc_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation, registered, carrying the
// rectangle along. Depends on rrbc_pkg.
`default_nettype none

module rrbc_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  rrbc_pkg::cordic_t d_i,
  output logic              vld_o,
  output rrbc_pkg::cordic_t q_o
);
  import rrbc_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q60(SHIFT);

  logic signed [XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [Z_W-1:0]  z_in;
  logic                   vld_r;
  cordic_t                q_r, q_nxt;

  // Rotate toward z = 0
  always_comb begin
    x_in = d_i.x;
    y_in = d_i.y;
    z_in = d_i.z;
    dx   = y_in >>> SHIFT;
    dy   = x_in >>> SHIFT;
    q_nxt.item = d_i.item;
    if (!z_in[Z_W-1]) begin
      q_nxt.x = x_in - dx;
      q_nxt.y = y_in + dy;
      q_nxt.z = z_in - ATAN;
    end else begin
      q_nxt.x = x_in + dx;
      q_nxt.y = y_in - dy;
      q_nxt.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign vld_o = vld_r;
  assign q_o   = q_r;

endmodule

`default_nettype wire

### rtl/core/rrbc_place.sv
// Back end: quadrant fold and rounding of cos/sin, corner placement with
// half-away rounding, and the outline check. Depends on rrbc_pkg.
`default_nettype none

module rrbc_place #(
  parameter int TRIG_FRAC_BITS = rrbc_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  rrbc_pkg::cordic_t dat_i,
  input  rrbc_pkg::bounds_t bnd_i,
  output logic              vld_o,
  output logic              inside_o,
  output logic [1:0]        corner_o
);
  import rrbc_pkg::*;

  localparam int CS_W  = TRIG_FRAC_BITS + 2;
  localparam int SH    = WORK_BITS - TRIG_FRAC_BITS;
  localparam int P_W   = CS_W + 32;
  localparam int T_W   = P_W + 1;
  localparam int FL_SH = TRIG_FRAC_BITS + 1;
  localparam logic signed [XY_W-1:0] HALF_R   = XY_W'(1) << (SH - 1);
  localparam logic [FL_SH-1:0]       REM_HALF = FL_SH'(1) << TRIG_FRAC_BITS;

  // Stage C: quadrant fold
  logic                   vld_c_r;
  item_t                  item_c_r;
  logic signed [XY_W-1:0] c_c_r, s_c_r, c_nxt, s_nxt, xs, ys;

  always_comb begin
    xs = dat_i.item.byp ? ONE_Q : dat_i.x;
    ys = dat_i.item.byp ? '0 : dat_i.y;
    case (dat_i.item.quad)
      2'd0:    begin c_nxt = xs;  s_nxt = ys;  end
      2'd1:    begin c_nxt = -ys; s_nxt = xs;  end
      2'd2:    begin c_nxt = -xs; s_nxt = -ys; end
      default: begin c_nxt = ys;  s_nxt = -xs; end
    endcase
  end

  always_ff @(posedge clk) begin
    item_c_r <= dat_i.item;
    c_c_r    <= c_nxt;
    s_c_r    <= s_nxt;
  end

  // Stage D: round to TRIG_FRAC_BITS, halves away from zero
  logic                   vld_d_r;
  item_t                  item_d_r;
  logic signed [CS_W-1:0] cs_d_r, sn_d_r;
  logic signed [XY_W-1:0] c_rnd, s_rnd;

  always_comb begin
    c_rnd = (c_c_r + (c_c_r[XY_W-1] ? HALF_R - XY_W'(1) : HALF_R)) >>> SH;
    s_rnd = (s_c_r + (s_c_r[XY_W-1] ? HALF_R - XY_W'(1) : HALF_R)) >>> SH;
  end

  always_ff @(posedge clk) begin
    item_d_r <= item_c_r;
    cs_d_r   <= $signed(c_rnd[CS_W-1:0]);
    sn_d_r   <= $signed(s_rnd[CS_W-1:0]);
  end

  // Stage E: size times trig products
  logic                  vld_e_r;
  item_t                 item_e_r;
  logic signed [P_W-1:0] p_e_r, q_e_r, r_e_r, s_e_r;
  logic signed [P_W-1:0] w_s, h_s;

  always_comb begin
    w_s = P_W'($signed({1'b0, item_d_r.w}));
    h_s = P_W'($signed({1'b0, item_d_r.h}));
  end

  always_ff @(posedge clk) begin
    item_e_r <= item_d_r;
    p_e_r    <= w_s * P_W'(cs_d_r);
    q_e_r    <= h_s * P_W'(sn_d_r);
    r_e_r    <= w_s * P_W'(sn_d_r);
    s_e_r    <= h_s * P_W'(cs_d_r);
  end

  // Stage F: shared sums and differences
  logic                  vld_f_r;
  item_t                 item_f_r;
  logic signed [T_W-1:0] a_f_r, b_f_r, c_f_r, d_f_r;

  always_ff @(posedge clk) begin
    item_f_r <= item_e_r;
    a_f_r    <= T_W'(p_e_r) + T_W'(q_e_r);
    b_f_r    <= T_W'(p_e_r) - T_W'(q_e_r);
    c_f_r    <= T_W'(r_e_r) + T_W'(s_e_r);
    d_f_r    <= T_W'(r_e_r) - T_W'(s_e_r);
  end

  // Stage G: per-corner offsets, scaled by 2^(TRIG_FRAC_BITS+1)
  logic                  vld_g_r;
  item_t                 item_g_r;
  logic signed [T_W-1:0] tx_g_r [4];
  logic signed [T_W-1:0] ty_g_r [4];

  always_ff @(posedge clk) begin
    item_g_r  <= item_f_r;
    tx_g_r[0] <= -b_f_r;
    ty_g_r[0] <= -c_f_r;
    tx_g_r[1] <= a_f_r;
    ty_g_r[1] <= d_f_r;
    tx_g_r[2] <= b_f_r;
    ty_g_r[2] <= c_f_r;
    tx_g_r[3] <= -a_f_r;
    ty_g_r[3] <= -d_f_r;
  end

  // Stage H: center plus floor of offset, rounding flags from the remainder
  logic                    vld_h_r;
  logic signed [NUM_W-1:0] nx_h_r [4];
  logic signed [NUM_W-1:0] ny_h_r [4];
  logic signed [NUM_W-1:0] nx_nxt [4];
  logic signed [NUM_W-1:0] ny_nxt [4];
  logic [3:0]              gex_h_r, gtx_h_r, gey_h_r, gty_h_r;
  logic [3:0]              gex_nxt, gtx_nxt, gey_nxt, gty_nxt;
  logic signed [T_W-1:0]   flx [4];
  logic signed [T_W-1:0]   fly [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      flx[i]     = tx_g_r[i] >>> FL_SH;
      fly[i]     = ty_g_r[i] >>> FL_SH;
      nx_nxt[i]  = NUM_W'(item_g_r.cx) + $signed(flx[i][NUM_W-1:0]);
      ny_nxt[i]  = NUM_W'(item_g_r.cy) + $signed(fly[i][NUM_W-1:0]);
      gex_nxt[i] = tx_g_r[i][FL_SH-1:0] >= REM_HALF;
      gtx_nxt[i] = tx_g_r[i][FL_SH-1:0] > REM_HALF;
      gey_nxt[i] = ty_g_r[i][FL_SH-1:0] >= REM_HALF;
      gty_nxt[i] = ty_g_r[i][FL_SH-1:0] > REM_HALF;
    end
  end

  always_ff @(posedge clk) begin
    nx_h_r  <= nx_nxt;
    ny_h_r  <= ny_nxt;
    gex_h_r <= gex_nxt;
    gtx_h_r <= gtx_nxt;
    gey_h_r <= gey_nxt;
    gty_h_r <= gty_nxt;
  end

  // Stage I: round up, threshold picked by sign of the floored value
  logic                    vld_i_r;
  logic signed [NUM_W-1:0] px_i_r [4];
  logic signed [NUM_W-1:0] py_i_r [4];
  logic signed [NUM_W-1:0] px_nxt [4];
  logic signed [NUM_W-1:0] py_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px_nxt[i] = nx_h_r[i] +
                  NUM_W'(nx_h_r[i][NUM_W-1] ? gtx_h_r[i] : gex_h_r[i]);
      py_nxt[i] = ny_h_r[i] +
                  NUM_W'(ny_h_r[i][NUM_W-1] ? gty_h_r[i] : gey_h_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    px_i_r <= px_nxt;
    py_i_r <= py_nxt;
  end

  // Stage J: outline compare, first failing corner wins
  logic                    vld_j_r, inside_j_r;
  logic [1:0]              corner_j_r, corner_nxt;
  logic [3:0]              fail;
  logic signed [NUM_W-1:0] lo_x, lo_y, hi_x, hi_y;

  always_comb begin
    lo_x = NUM_W'(bnd_i.min_x);
    lo_y = NUM_W'(bnd_i.min_y);
    hi_x = NUM_W'(bnd_i.max_x);
    hi_y = NUM_W'(bnd_i.max_y);
    for (int i = 0; i < 4; i++) begin
      fail[i] = (px_i_r[i] < lo_x) || (px_i_r[i] > hi_x) ||
                (py_i_r[i] < lo_y) || (py_i_r[i] > hi_y);
    end
    corner_nxt = CORNER_BL;
    for (int i = 3; i >= 0; i--) begin
      if (fail[i]) begin
        corner_nxt = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    inside_j_r <= ~|fail;
    corner_j_r <= corner_nxt;
  end

  // Valid bits through the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
      vld_h_r <= 1'b0;
      vld_i_r <= 1'b0;
      vld_j_r <= 1'b0;
    end else begin
      vld_c_r <= vld_i;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
      vld_h_r <= vld_g_r;
      vld_i_r <= vld_h_r;
      vld_j_r <= vld_i_r;
    end
  end

  assign vld_o    = vld_j_r;
  assign inside_o = inside_j_r;
  assign corner_o = corner_j_r;

endmodule

`default_nettype wire

### rtl/core/rotated_rect_bounds_check.sv
// Top level of the rotated rectangle bounds check: register file, front
// stage, CORDIC cell chain and back end. Depends on rrbc_pkg and submodules.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+-------------------------------
//   input    | start (accepted when !busy)     | in_center_x/y, in_rect_width/
//            |                                 | height, in_angle
//   result   | out_valid strobe, one cycle     | out_inside_res,
//            |                                 | out_failed_corner
//   config   | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
//
// One transaction per clock; every transaction returns one result, after passing
// through the front stage, the CORDIC cell chain and the back end.
// busy is high only during reset (rst_n, synchronous, active low), which
// clears every valid bit and the outline registers.
// The receiver cannot stall: results are a one-cycle strobe.
`default_nettype none

module rotated_rect_bounds_check #(
  parameter int TRIG_FRAC_BITS = rrbc_pkg::DEF_TRIG_FRAC_BITS,
  parameter int CORDIC_STAGES  = rrbc_pkg::DEF_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_rect_width,
  input  logic [30:0]        in_rect_height,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  output logic               out_inside_res,
  output logic [1:0]         out_failed_corner,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrbc_pkg::*;

  localparam logic [1:0] REG_MIN_X  = 2'd0;
  localparam logic [1:0] REG_MIN_Y  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;
  localparam int         LAT        = FRONT_LAT + CORDIC_STAGES + BACK_LAT;

  logic               acc, wr_en;
  logic signed [31:0] min_x_r, min_y_r;
  logic [30:0]        width_r, height_r;
  bounds_t            bnd_r;

  assign busy   = ~rst_n;
  assign acc    = start && !busy;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Outline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r  <= '0;
      min_y_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MIN_X:  min_x_r  <= $signed(pwdata);
        REG_MIN_Y:  min_y_r  <= $signed(pwdata);
        REG_WIDTH:  width_r  <= pwdata[30:0];
        REG_HEIGHT: height_r <= pwdata[30:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_X:  prdata = min_x_r;
      REG_MIN_Y:  prdata = min_y_r;
      REG_WIDTH:  prdata = {1'b0, width_r};
      REG_HEIGHT: prdata = {1'b0, height_r};
      default:    prdata = '0;
    endcase
  end

  // Registered inclusive bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r <= '0;
    end else begin
      bnd_r.min_x <= min_x_r;
      bnd_r.min_y <= min_y_r;
      bnd_r.max_x <= 33'(min_x_r) + $signed({2'b0, width_r});
      bnd_r.max_y <= 33'(min_y_r) + $signed({2'b0, height_r});
    end
  end

  // Front stage
  logic    vld_c [CORDIC_STAGES+1];
  cordic_t dat_c [CORDIC_STAGES+1];

  rrbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_i         (acc),
    .center_x_i    (in_center_x),
    .center_y_i    (in_center_y),
    .rect_width_i  (in_rect_width),
    .rect_height_i (in_rect_height),
    .angle_i       (in_angle),
    .vld_o         (vld_c[0]),
    .dat_o         (dat_c[0])
  );

  // CORDIC cell chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rrbc_cordic_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_c[g]),
      .d_i   (dat_c[g]),
      .vld_o (vld_c[g+1]),
      .q_o   (dat_c[g+1])
    );
  end

  // Corner placement and outline check
  rrbc_place #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (vld_c[CORDIC_STAGES]),
    .dat_i    (dat_c[CORDIC_STAGES]),
    .bnd_i    (bnd_r),
    .vld_o    (out_valid),
    .inside_o (out_inside_res),
    .corner_o (out_failed_corner)
  );

  // Every accepted transaction yields a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result without matching transaction");

  // Inside results report corner zero
  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |-> (out_failed_corner == CORNER_BL))
    else $error("inside result with nonzero corner");

  // Reset flushes the pipeline
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

### tb/rrbc_tb_pkg.sv
// Register map of the board outline as seen from the configuration port.
// Shared by the containment monitor and the testbench top. No dependencies.
`timescale 1ns / 1ps

package rrbc_tb_pkg;

  // Register index; the byte address is index * 4
  typedef enum logic [1:0] {
    REG_MIN_X,
    REG_MIN_Y,
    REG_WIDTH,
    REG_HEIGHT
  } board_reg_e;

endpackage

### tb/containment_monitor.sv
// Containment monitor: watches the rectangle, result and configuration channels,
// predicts each verdict and compares it. Depends on rrbc_pkg and rrbc_tb_pkg.
`timescale 1ns / 1ps

module containment_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_rect_width,
  input  logic [30:0]        in_rect_height,
  input  logic [15:0]        in_angle,
  input  logic               out_valid,
  input  logic               out_inside_res,
  input  logic [1:0]         out_failed_corner,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);
  import rrbc_tb_pkg::*;

  // Trig formats: CORDIC works in Q40, sine/cosine leave in Q24
  localparam int     TRIG_FRAC    = rrbc_pkg::DEF_TRIG_FRAC_BITS;
  localparam int     CORDIC_STEPS = rrbc_pkg::DEF_CORDIC_STAGES;
  localparam int     XY_FRAC      = 40;
  localparam longint PI_Q60       = 64'h3243F6A8885A308D;
  localparam longint GAIN_Q32     = 64'd2608131496;

  typedef struct packed {
    logic       fits;
    logic [1:0] corner;
  } verdict_t;

  verdict_t pending_verdicts[$];
  longint   atan_q60[32];

  // Shadow copy of the outline registers
  longint bound_min_x, bound_min_y, bound_width, bound_height;

  // atan(2^-i) in Q60: pi/4 first, then the alternating odd-power series
  initial begin
    longint unsigned term;
    longint          acc;
    atan_q60[0] = PI_Q60 >>> 2;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
        acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      atan_q60[i] = acc;
    end
  end

  // Round half away from zero while dropping sh fraction bits
  function automatic longint round_away(input longint v, input int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  // Cosine and sine of a binary angle, Q24
  function automatic void unit_vector(input logic [15:0] ang,
                                     output longint cos_q, output longint sin_q);
    longint x, y, z, dx, dy, c, s;
    if (ang[13:0] == 14'd0) begin
      // exact on right angles
      x = longint'(1) << XY_FRAC;
      y = 0;
    end else begin
      z = longint'(ang[13:0]) * (PI_Q60 >>> 15);
      x = GAIN_Q32 <<< (XY_FRAC - 32);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q60[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q60[i];
        end
      end
    end
    // quadrant fold
    case (ang[15:14])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    cos_q = round_away(c, XY_FRAC - TRIG_FRAC);
    sin_q = round_away(s, XY_FRAC - TRIG_FRAC);
  endfunction

  // center + (a*ta + b*tb) / 2^(TRIG_FRAC+1), halves away from zero by sign of floor
  function automatic longint place_corner(input longint ctr, input longint a, input longint ta,
                                          input longint b, input longint tb);
    longint sum, frac, n;
    sum  = a * ta + b * tb;
    frac = sum & ((longint'(1) << (TRIG_FRAC + 1)) - 1);
    n    = ctr + (sum >>> (TRIG_FRAC + 1));
    if (n >= 0) begin
      n = n + ((frac >= (longint'(1) << TRIG_FRAC)) ? 1 : 0);
    end else begin
      n = n + ((frac > (longint'(1) << TRIG_FRAC)) ? 1 : 0);
    end
    return n;
  endfunction

  // Verdict for one rectangle against the current outline
  function automatic verdict_t predict_containment(input longint cx, input longint cy,
                                                   input longint w, input longint h,
                                                   input logic [15:0] ang);
    verdict_t   v;
    longint     cs, sn, a, hy, px, py, max_x, max_y;
    logic [1:0] corner;
    v.fits   = 1'b1;
    v.corner = rrbc_pkg::CORNER_BL;
    unit_vector(ang, cs, sn);
    max_x = bound_min_x + bound_width;
    max_y = bound_min_y + bound_height;
    // corner codes run in check order
    for (int i = 0; i < 4; i++) begin
      corner = 2'(i);
      a  = (corner == rrbc_pkg::CORNER_BR || corner == rrbc_pkg::CORNER_TR) ? w : -w;
      hy = (corner == rrbc_pkg::CORNER_TR || corner == rrbc_pkg::CORNER_TL) ? h : -h;
      px = place_corner(cx, a, cs, -hy, sn);
      py = place_corner(cy, a, sn, hy, cs);
      if (v.fits && (px < bound_min_x || px > max_x || py < bound_min_y || py > max_y)) begin
        v.fits   = 1'b0;
        v.corner = corner;
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] shadow_value(input board_reg_e idx);
    case (idx)
      REG_MIN_X: return 32'(bound_min_x);
      REG_MIN_Y: return 32'(bound_min_y);
      REG_WIDTH: return 32'(bound_width);
      default:   return 32'(bound_height);
    endcase
  endfunction

  always @(posedge clk) begin : watch
    verdict_t   want;
    board_reg_e idx;
    idx = board_reg_e'(paddr[3:2]);
    if (!rst_n) begin
      // outline registers clear on reset, nothing in flight
      bound_min_x  = 0;
      bound_min_y  = 0;
      bound_width  = 0;
      bound_height = 0;
      pending_verdicts.delete();
    end else begin
      // result transaction: compare with the oldest prediction
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with no transaction pending (inside %0b corner %0d)",
                   $time, out_inside_res, out_failed_corner);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_inside_res !== want.fits) begin
            $display("%0t: inside_res expected %0b, got %0b",
                     $time, want.fits, out_inside_res);
            mismatches++;
          end
          if (out_failed_corner !== want.corner) begin
            $display("%0t: failed_corner expected %0d, got %0d",
                     $time, want.corner, out_failed_corner);
            mismatches++;
          end
        end
      end
      // rectangle transaction
      if (start && !busy)
        pending_verdicts.push_back(predict_containment(
          longint'(in_center_x), longint'(in_center_y),
          longint'(in_rect_width), longint'(in_rect_height), in_angle));
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_MIN_X:  bound_min_x  = longint'(signed'(pwdata));
            REG_MIN_Y:  bound_min_y  = longint'(signed'(pwdata));
            REG_WIDTH:  bound_width  = longint'(pwdata[30:0]);
            REG_HEIGHT: bound_height = longint'(pwdata[30:0]);
          endcase
        end else if (prdata !== shadow_value(idx)) begin
          $display("%0t: register %s read expected %h, got %h",
                   $time, idx.name(), shadow_value(idx), prdata);
          mismatches++;
        end
      end
    end
    outstanding = pending_verdicts.size();
  end

endmodule

### tb/testbench.sv
// Testbench top for rotated_rect_bounds_check: clock, reset, outline setup and
// rectangle stimulus. Depends on the RTL, rrbc_tb_pkg and containment_monitor.
`timescale 1ns / 1ps

module testbench;
  import rrbc_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = rrbc_pkg::DEF_CORDIC_STAGES + 16;
  localparam int PHASE_ITEMS   = 170;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_center_x;
  logic signed [31:0] in_center_y;
  logic [30:0]        in_rect_width;
  logic [30:0]        in_rect_height;
  logic [15:0]        in_angle;
  logic               out_valid;
  logic               out_inside_res;
  logic [1:0]         out_failed_corner;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;

  // Outline as last programmed, used only to aim rectangles
  longint board_x, board_y, board_w, board_h;
  bit     steady;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  rotated_rect_bounds_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_inside_res   (out_inside_res),
    .out_failed_corner(out_failed_corner),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  containment_monitor i_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_inside_res   (out_inside_res),
    .out_failed_corner(out_failed_corner),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("rotated_rect_bounds_check test failed");
      $finish;
    end
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One register transaction: setup phase, access phase, then a return to idle
  task automatic reg_access(input logic wr, input board_reg_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Program the outline and read every register back
  task automatic set_board(input logic [31:0] mx, input logic [31:0] my,
                           input logic [31:0] ww, input logic [31:0] hh);
    reg_access(1'b1, REG_MIN_X, mx);
    reg_access(1'b1, REG_MIN_Y, my);
    reg_access(1'b1, REG_WIDTH, ww);
    reg_access(1'b1, REG_HEIGHT, hh);
    reg_access(1'b0, REG_MIN_X, '0);
    reg_access(1'b0, REG_MIN_Y, '0);
    reg_access(1'b0, REG_WIDTH, '0);
    reg_access(1'b0, REG_HEIGHT, '0);
    board_x = longint'(signed'(mx));
    board_y = longint'(signed'(my));
    board_w = longint'(ww[30:0]);
    board_h = longint'(hh[30:0]);
  endtask

  // Present one rectangle and hold it until accepted; start stays high after
  task automatic send_rect(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [30:0] w, input logic [30:0] h,
                           input logic [15:0] ang);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_rect_width  <= w;
    in_rect_height <= h;
    in_angle       <= ang;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every verdict has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic send_random_rect();
    longint      cx, cy, xh, yh;
    logic [30:0] w, h;
    logic [15:0] ang;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // raw noise over every bit
      send_rect($urandom, $urandom, 31'($urandom), 31'($urandom), 16'($urandom));
    end else begin
      w = 31'($urandom_range(0, board_w >> $urandom_range(0, 4)));
      h = 31'($urandom_range(0, board_h >> $urandom_range(0, 4)));
      if (pick < 40) begin
        ang = {2'($urandom_range(0, 3)), 14'd0};
      end else if (pick < 50) begin
        ang = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
      end else begin
        ang = 16'($urandom);
      end
      if (pick < 40) begin
        // right angle: put a corner on an outline edge, give or take one
        xh = (ang[14] ? longint'(h) : longint'(w)) / 2;
        yh = (ang[14] ? longint'(w) : longint'(h)) / 2;
        cx = $urandom_range(0, 1) ? board_x + xh : board_x + board_w - xh;
        cy = $urandom_range(0, 1) ? board_y + yh : board_y + board_h - yh;
        cx = cx + longint'($urandom_range(0, 2)) - 1;
        cy = cy + longint'($urandom_range(0, 2)) - 1;
      end else begin
        cx = board_x + longint'($urandom_range(0, board_w)) + longint'($urandom_range(0, 64)) - 32;
        cy = board_y + longint'($urandom_range(0, board_h)) + longint'($urandom_range(0, 64)) - 32;
      end
      send_rect(32'(cx), 32'(cy), w, h, ang);
    end
  endtask

  initial begin
    longint span;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_center_x    <= '0;
    in_center_y    <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_angle       <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    board_x = 0;
    board_y = 0;
    board_w = 0;
    board_h = 0;
    steady  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    // Outline out of reset is a single point at the origin
    send_rect(32'd0, 32'd0, 31'd0, 31'd0, 16'd0);
    send_rect(32'd0, 32'd0, 31'd1, 31'd0, 16'd0);
    send_rect(32'd1, 32'd0, 31'd0, 31'd0, 16'd0);
    drain();

    // Directed: x in [-1000, 1000], y in [-2000, 2000]
    set_board(-32'sd1000, -32'sd2000, 32'd2000, 32'd4000);
    send_rect(32'd0, 32'd0, 31'd2000, 31'd4000, 16'd0);       // exact fit
    send_rect(32'd0, 32'd0, 31'd2001, 31'd4000, 16'd0);       // half past the edge
    send_rect(32'd0, 32'd0, 31'd4000, 31'd2000, 16'd16384);   // quarter turn, exact
    send_rect(32'd0, 32'd0, 31'd2000, 31'd4000, 16'd32768);
    send_rect(32'd0, 32'd0, 31'd2000, 31'd4000, 16'd49152);
    send_rect(32'd0, 32'd0, 31'd1000, 31'd1000, 16'd8192);    // eighth turn
    send_rect(32'd0, 32'd0, 31'd1000, 31'd3000, 16'd1);       // smallest residual
    send_rect(32'd0, 32'd0, 31'd1000, 31'd3000, 16'd16383);   // largest residual
    send_rect(32'd0, 32'd0, 31'd1000, 31'd3000, 16'd16385);
    send_rect(32'd0, 32'd0, 31'd1000, 31'd3000, 16'd65535);
    send_rect(32'd999, 32'd0, 31'd2, 31'd0, 16'd0);           // touches right edge
    send_rect(32'd1000, 32'd0, 31'd2, 31'd0, 16'd0);          // right corner leaves
    send_rect(32'd0, 32'd1999, 31'd0, 31'd4, 16'd0);          // top right leaves first
    send_rect(-32'sd300, 32'd0, 31'd1000, 31'd1000, 16'd8192); // only top left leaves
    send_rect(-32'sd1000, 32'd0, 31'd1, 31'd0, 16'd0);        // -1000.5 rounds outward
    send_rect(32'd1000, 32'd0, 31'd1, 31'd0, 16'd0);          // 1000.5 rounds outward
    send_rect(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd12345);
    send_rect(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    drain();

    // Lowest outline: x and y in [-2^31, -1]
    set_board(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_rect(32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 16'd0);
    send_rect(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0, 31'd0, 16'd0);
    send_rect(32'd0, 32'hFFFF_FFFF, 31'd0, 31'd0, 16'd0);
    send_rect(32'hC000_0000, 32'hC000_0000, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 16'd0);
    send_rect(32'hC000_0000, 32'hC000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd40000);
    drain();

    // Random phases, each with its own outline
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        set_board($urandom, $urandom, $urandom, $urandom);
      end else if (p == 1) begin
        // highest outline, reaching past the 32-bit range
        set_board(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end else begin
        span = longint'(1) << $urandom_range(2, 30);
        set_board(32'(-(span / 2) + longint'($urandom_range(0, 100))),
                  32'(-(span / 2) + longint'($urandom_range(0, 100))),
                  32'($urandom_range(span / 2, span)),
                  32'($urandom_range(span / 2, span)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 199) == 0) drain();
        send_random_rect();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rotated_rect_bounds_check test passed");
    end else begin
      $display("rotated_rect_bounds_check test failed");
    end
    $finish;
  end

endmodule

### rotated_rect_bounds_check.f
rtl/core/rrbc_pkg.sv
rtl/core/rrbc_front.sv
rtl/core/rrbc_cordic_cell.sv
rtl/core/rrbc_place.sv
rtl/core/rotated_rect_bounds_check.sv
tb/rrbc_tb_pkg.sv
tb/containment_monitor.sv
tb/testbench.sv
